@@ design/spr_pkg.sv @@
// spr_pkg: widths, codes, types and helpers of the segment proximity reveal table
// depends on nothing; imported by spr_mac, segment_proximity_reveal_table and the testbench
`timescale 1ns / 1ps

package spr_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int MAX_POINTS   = 64;
   localparam int COORD_BITS   = 24;

   localparam int SEG_IDX_W = $clog2(MAX_SEGMENTS);
   localparam int PT_IDX_W  = $clog2(MAX_POINTS);
   localparam int MAX_ENT   = (MAX_SEGMENTS > MAX_POINTS) ? MAX_SEGMENTS : MAX_POINTS;
   localparam int CNT_W     = $clog2(MAX_ENT + 1);

   localparam int DIFF_W = COORD_BITS + 1;       // difference of two coordinates
   localparam int OP_W   = DIFF_W + 2;           // signed multiplier operand
   localparam int LIMB_W = OP_W - 1;             // unsigned limb of a wide value
   localparam int XW     = 2 * LIMB_W;           // two-limb value
   localparam int PROD_W = 2 * OP_W;
   localparam int ACC_W  = 4 * LIMB_W + 2;
   localparam int R2_W   = 2 * (COORD_BITS - 1);
   localparam int LEN_W  = 2 * DIFF_W;
   localparam int STEP_W = 4;

   localparam int FUNC_W   = 3;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 7;

   typedef enum logic [FUNC_W-1:0] {
      F_CLEAR    = 3'd0,
      F_ADD_SEG  = 3'd1,
      F_ADD_PT   = 3'd2,
      F_REVEAL   = 3'd3,
      F_READ_SEG = 3'd4,
      F_READ_PT  = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SH_NONE = 2'd0,
      SH_ONE  = 2'd1,
      SH_TWO  = 2'd2
   } shift_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DONE,
      ST_SEG_RD,
      ST_SEG_LD,
      ST_PT_RD,
      ST_PT_LD,
      ST_CALC
   } state_type;

   typedef enum logic [2:0] {
      PH_RAD,
      PH_LEN,
      PH_DOT,
      PH_NEAR,
      PH_FAR,
      PH_CROSS,
      PH_PERP
   } phase_type;

   typedef struct packed {
      logic                    issue;
      logic                    load;
      logic signed [ACC_W-1:0] init;
      logic signed [OP_W-1:0]  op_a;
      logic signed [OP_W-1:0]  op_b;
      logic                    neg;
      shift_type               shift;
   } mac_cmd_type;

   // partial products issued in each phase
   function automatic logic [STEP_W-1:0] phase_ops(input phase_type ph);
      logic [STEP_W-1:0] n;
      case (ph)
         PH_RAD:  n = STEP_W'(1);
         PH_PERP: n = STEP_W'(8);
         default: n = STEP_W'(2);
      endcase
      return n;
   endfunction

endpackage

@@ design/segment_proximity_reveal_table.sv @@
// segment_proximity_reveal_table: segment and point tables with sticky discovered bits
// depends on spr_pkg and spr_mac
`timescale 1ns / 1ps
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  request  | start, busy               | req_func, req_index, req_first_x/y,
//           |                           | req_second_x/y, req_radius
//  response | rsp_strobe (one cycle)    | rsp_status, rsp_flag, rsp_any_discovered,
//           |                           | rsp_segment_total, rsp_point_total
//
//  a transaction is taken when start is high and busy low; busy stays high until
//  the response strobe has gone by
//  clear, append and read: accepted in idle, then answered from the done state
//  reveal: radius, then segments, then points; the one shared multiplier takes
//  one partial product per cycle, so the segment cross term sets the worst case
//  reset (synchronous) empties both tables; memories need no clearing pass
//  the receiver cannot stall: the response is shown for exactly one cycle

module segment_proximity_reveal_table import spr_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [FUNC_W-1:0]            req_func,
   input  logic [INDEX_W-1:0]           req_index,
   input  logic signed [COORD_BITS-1:0] req_first_x,
   input  logic signed [COORD_BITS-1:0] req_first_y,
   input  logic signed [COORD_BITS-1:0] req_second_x,
   input  logic signed [COORD_BITS-1:0] req_second_y,
   input  logic signed [COORD_BITS-1:0] req_radius,
   output logic                         rsp_strobe,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic                         rsp_flag,
   output logic                         rsp_any_discovered,
   output logic [TOTAL_W-1:0]           rsp_segment_total,
   output logic [TOTAL_W-1:0]           rsp_point_total
);

   // sequencer state
   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [STEP_W-1:0] step_ff, step_in, nops;
   logic [CNT_W-1:0]  ent_ff, ent_in, ent_next;
   logic              pts_ff, pts_in;

   // table state
   logic [CNT_W-1:0]        seg_cnt_ff, pt_cnt_ff;
   logic [MAX_SEGMENTS-1:0] seg_seen_ff;
   logic [MAX_POINTS-1:0]   pt_seen_ff;
   logic                    seen_any_ff;
   logic [4*COORD_BITS-1:0] seg_mem [MAX_SEGMENTS];
   logic [2*COORD_BITS-1:0] pt_mem [MAX_POINTS];
   logic [4*COORD_BITS-1:0] seg_rd_ff;
   logic [2*COORD_BITS-1:0] pt_rd_ff;

   // working registers of one reveal
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff, rad_ff;
   logic signed [DIFF_W-1:0]     ex_ff, ey_ff, wx_ff, wy_ff, vx_ff, vy_ff;
   logic [R2_W-1:0]              r2_ff;
   logic [LEN_W-1:0]             len2_ff;
   logic [XW-1:0]                xmag_ff;
   status_type                   status_ff;
   logic                         flag_ff;

   mac_cmd_type             cmd;
   logic signed [ACC_W-1:0] acc, neg_r2;
   logic                    accept, seg_full, pt_full, hit, entry_done;
   logic                    latch_r2, latch_len2, latch_x;
   logic [XW-1:0]           r2w, len2w;
   logic signed [OP_W-1:0]  xl, xh, rl, rh, ll, lh;

   spr_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .acc   (acc)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign seg_full = (seg_cnt_ff >= CNT_W'(MAX_SEGMENTS));
   assign pt_full  = (pt_cnt_ff >= CNT_W'(MAX_POINTS));
   assign nops     = phase_ops(phase_ff);
   assign ent_next = ent_ff + CNT_W'(1);
   assign neg_r2   = ACC_W'(0) - $signed(ACC_W'(r2_ff));

   // limbs of the wide operands of the perpendicular test
   assign r2w   = XW'(r2_ff);
   assign len2w = XW'(len2_ff);
   assign xl    = $signed({1'b0, xmag_ff[LIMB_W-1:0]});
   assign xh    = $signed({1'b0, xmag_ff[XW-1:LIMB_W]});
   assign rl    = $signed({1'b0, r2w[LIMB_W-1:0]});
   assign rh    = $signed({1'b0, r2w[XW-1:LIMB_W]});
   assign ll    = $signed({1'b0, len2w[LIMB_W-1:0]});
   assign lh    = $signed({1'b0, len2w[XW-1:LIMB_W]});

   // closest distance within radius when the running sum is not positive
   assign hit = acc[ACC_W-1] || (acc == '0);

   // sequencer: next state and the shared unit's command
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      step_in    = step_ff;
      ent_in     = ent_ff;
      pts_in     = pts_ff;
      cmd        = '0;
      cmd.shift  = SH_NONE;
      latch_r2   = 1'b0;
      latch_len2 = 1'b0;
      latch_x    = 1'b0;
      entry_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_func == F_REVEAL) begin
                  cmd.load = 1'b1;
                  phase_in = PH_RAD;
                  step_in  = '0;
                  state_in = ST_CALC;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: state_in = ST_IDLE;
         ST_SEG_RD: state_in = ST_SEG_LD;
         ST_SEG_LD: begin
            cmd.load = 1'b1;
            phase_in = PH_LEN;
            step_in  = '0;
            state_in = ST_CALC;
         end
         ST_PT_RD: state_in = ST_PT_LD;
         ST_PT_LD: begin
            cmd.load = 1'b1;
            cmd.init = neg_r2;
            phase_in = PH_NEAR;
            step_in  = '0;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (step_ff < nops) begin
               cmd.issue = 1'b1;
               step_in   = step_ff + STEP_W'(1);
               case (phase_ff)
                  PH_RAD: begin
                     cmd.op_a = OP_W'(rad_ff);
                     cmd.op_b = OP_W'(rad_ff);
                  end
                  PH_LEN: begin
                     cmd.op_a = (step_ff == '0) ? OP_W'(ex_ff) : OP_W'(ey_ff);
                     cmd.op_b = cmd.op_a;
                  end
                  PH_DOT: begin
                     cmd.op_a = (step_ff == '0) ? OP_W'(ex_ff) : OP_W'(ey_ff);
                     cmd.op_b = (step_ff == '0) ? OP_W'(wx_ff) : OP_W'(wy_ff);
                  end
                  PH_NEAR: begin
                     cmd.op_a = (step_ff == '0) ? OP_W'(wx_ff) : OP_W'(wy_ff);
                     cmd.op_b = cmd.op_a;
                  end
                  PH_FAR: begin
                     cmd.op_a = (step_ff == '0) ? OP_W'(vx_ff) : OP_W'(vy_ff);
                     cmd.op_b = cmd.op_a;
                  end
                  PH_CROSS: begin
                     cmd.op_a = (step_ff == '0) ? OP_W'(ex_ff) : OP_W'(ey_ff);
                     cmd.op_b = (step_ff == '0) ? OP_W'(wy_ff) : OP_W'(wx_ff);
                     cmd.neg  = (step_ff != '0);
                  end
                  PH_PERP: begin
                     // cross squared minus radius squared times length squared
                     case (step_ff)
                        STEP_W'(0): begin
                           cmd.op_a = xl; cmd.op_b = xl;
                        end
                        STEP_W'(1): begin
                           cmd.op_a = xl; cmd.op_b = xh; cmd.shift = SH_ONE;
                        end
                        STEP_W'(2): begin
                           cmd.op_a = xh; cmd.op_b = xl; cmd.shift = SH_ONE;
                        end
                        STEP_W'(3): begin
                           cmd.op_a = xh; cmd.op_b = xh; cmd.shift = SH_TWO;
                        end
                        STEP_W'(4): begin
                           cmd.op_a = rl; cmd.op_b = ll; cmd.neg = 1'b1;
                        end
                        STEP_W'(5): begin
                           cmd.op_a = rl; cmd.op_b = lh; cmd.neg = 1'b1;
                           cmd.shift = SH_ONE;
                        end
                        STEP_W'(6): begin
                           cmd.op_a = rh; cmd.op_b = ll; cmd.neg = 1'b1;
                           cmd.shift = SH_ONE;
                        end
                        default: begin
                           cmd.op_a = rh; cmd.op_b = lh; cmd.neg = 1'b1;
                           cmd.shift = SH_TWO;
                        end
                     endcase
                  end
                  default: cmd.issue = 1'b0;
               endcase
            end else if (step_ff == nops) begin
               // last product still on its way into the accumulator
               step_in = step_ff + STEP_W'(1);
            end else begin
               step_in = '0;
               case (phase_ff)
                  PH_RAD: begin
                     latch_r2 = 1'b1;
                     ent_in   = '0;
                     pts_in   = 1'b0;
                     if (seg_cnt_ff != '0) begin
                        state_in = ST_SEG_RD;
                     end else if (pt_cnt_ff != '0) begin
                        pts_in   = 1'b1;
                        state_in = ST_PT_RD;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  PH_LEN: begin
                     latch_len2 = 1'b1;
                     cmd.load   = 1'b1;
                     phase_in   = PH_DOT;
                  end
                  PH_DOT: begin
                     cmd.load = 1'b1;
                     if ((len2_ff == '0) || hit) begin
                        // degenerate segment or center behind the start
                        cmd.init = neg_r2;
                        phase_in = PH_NEAR;
                     end else if (acc >= $signed(ACC_W'(len2_ff))) begin
                        cmd.init = neg_r2;
                        phase_in = PH_FAR;
                     end else begin
                        phase_in = PH_CROSS;
                     end
                  end
                  PH_CROSS: begin
                     latch_x  = 1'b1;
                     cmd.load = 1'b1;
                     phase_in = PH_PERP;
                  end
                  default: begin
                     entry_done = 1'b1;
                     if (pts_ff) begin
                        if (ent_next == pt_cnt_ff) begin
                           state_in = ST_DONE;
                        end else begin
                           ent_in   = ent_next;
                           state_in = ST_PT_RD;
                        end
                     end else if (ent_next == seg_cnt_ff) begin
                        ent_in = '0;
                        if (pt_cnt_ff != '0) begin
                           pts_in   = 1'b1;
                           state_in = ST_PT_RD;
                        end else begin
                           state_in = ST_DONE;
                        end
                     end else begin
                        ent_in   = ent_next;
                        state_in = ST_SEG_RD;
                     end
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_RAD;
         step_ff  <= '0;
         ent_ff   <= '0;
         pts_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         ent_ff   <= ent_in;
         pts_ff   <= pts_in;
      end
   end

   // counts and discovered bits
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_cnt_ff  <= '0;
         pt_cnt_ff   <= '0;
         seg_seen_ff <= '0;
         pt_seen_ff  <= '0;
         seen_any_ff <= 1'b0;
      end else begin
         if (accept) begin
            case (req_func)
               F_CLEAR: begin
                  seg_cnt_ff  <= '0;
                  pt_cnt_ff   <= '0;
                  seg_seen_ff <= '0;
                  pt_seen_ff  <= '0;
                  seen_any_ff <= 1'b0;
               end
               F_ADD_SEG: begin
                  if (!seg_full) begin
                     seg_seen_ff[seg_cnt_ff[SEG_IDX_W-1:0]] <= 1'b0;
                     seg_cnt_ff <= seg_cnt_ff + CNT_W'(1);
                  end
               end
               F_ADD_PT: begin
                  if (!pt_full) begin
                     pt_seen_ff[pt_cnt_ff[PT_IDX_W-1:0]] <= 1'b0;
                     pt_cnt_ff <= pt_cnt_ff + CNT_W'(1);
                  end
               end
               default: ;
            endcase
         end
         if (entry_done) begin
            if (pts_ff) begin
               if (hit) begin
                  pt_seen_ff[ent_ff[PT_IDX_W-1:0]] <= 1'b1;
               end
               if (hit || pt_seen_ff[ent_ff[PT_IDX_W-1:0]]) begin
                  seen_any_ff <= 1'b1;
               end
            end else begin
               if (hit) begin
                  seg_seen_ff[ent_ff[SEG_IDX_W-1:0]] <= 1'b1;
               end
               if (hit || seg_seen_ff[ent_ff[SEG_IDX_W-1:0]]) begin
                  seen_any_ff <= 1'b1;
               end
            end
         end
      end
   end

   // entry memories, registered read at the walk pointer
   always_ff @(posedge clock) begin
      if (accept && (req_func == F_ADD_SEG) && !seg_full) begin
         seg_mem[seg_cnt_ff[SEG_IDX_W-1:0]] <=
            {req_first_x, req_first_y, req_second_x, req_second_y};
      end
      seg_rd_ff <= seg_mem[ent_ff[SEG_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept && (req_func == F_ADD_PT) && !pt_full) begin
         pt_mem[pt_cnt_ff[PT_IDX_W-1:0]] <= {req_first_x, req_first_y};
      end
      pt_rd_ff <= pt_mem[ent_ff[PT_IDX_W-1:0]];
   end

   // working registers and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cx_ff     <= req_first_x;
         cy_ff     <= req_first_y;
         rad_ff    <= req_radius[COORD_BITS-1] ? '0 : req_radius;
         status_ff <= STAT_DONE;
         flag_ff   <= 1'b0;
         case (req_func)
            F_ADD_SEG: if (seg_full) status_ff <= STAT_FULL;
            F_ADD_PT:  if (pt_full) status_ff <= STAT_FULL;
            F_READ_SEG: begin
               if (CNT_W'(req_index) >= seg_cnt_ff) begin
                  status_ff <= STAT_RANGE;
               end else begin
                  flag_ff <= seg_seen_ff[SEG_IDX_W'(req_index)];
               end
            end
            F_READ_PT: begin
               if (CNT_W'(req_index) >= pt_cnt_ff) begin
                  status_ff <= STAT_RANGE;
               end else begin
                  flag_ff <= pt_seen_ff[PT_IDX_W'(req_index)];
               end
            end
            default: ;
         endcase
      end
      if (state_ff == ST_SEG_LD) begin
         // layout: start x, start y, end x, end y
         ex_ff <= DIFF_W'($signed(seg_rd_ff[2*COORD_BITS-1:COORD_BITS]))
                - DIFF_W'($signed(seg_rd_ff[4*COORD_BITS-1:3*COORD_BITS]));
         ey_ff <= DIFF_W'($signed(seg_rd_ff[COORD_BITS-1:0]))
                - DIFF_W'($signed(seg_rd_ff[3*COORD_BITS-1:2*COORD_BITS]));
         wx_ff <= DIFF_W'(cx_ff)
                - DIFF_W'($signed(seg_rd_ff[4*COORD_BITS-1:3*COORD_BITS]));
         wy_ff <= DIFF_W'(cy_ff)
                - DIFF_W'($signed(seg_rd_ff[3*COORD_BITS-1:2*COORD_BITS]));
         vx_ff <= DIFF_W'(cx_ff)
                - DIFF_W'($signed(seg_rd_ff[2*COORD_BITS-1:COORD_BITS]));
         vy_ff <= DIFF_W'(cy_ff) - DIFF_W'($signed(seg_rd_ff[COORD_BITS-1:0]));
      end
      if (state_ff == ST_PT_LD) begin
         wx_ff <= DIFF_W'($signed(pt_rd_ff[2*COORD_BITS-1:COORD_BITS])) - DIFF_W'(cx_ff);
         wy_ff <= DIFF_W'($signed(pt_rd_ff[COORD_BITS-1:0])) - DIFF_W'(cy_ff);
      end
      if (latch_r2) begin
         r2_ff <= acc[R2_W-1:0];
      end
      if (latch_len2) begin
         len2_ff <= acc[LEN_W-1:0];
      end
      if (latch_x) begin
         xmag_ff <= acc[ACC_W-1] ? XW'(-acc) : XW'(acc);
      end
   end

   assign rsp_strobe         = (state_ff == ST_DONE);
   assign rsp_status         = status_ff;
   assign rsp_flag           = flag_ff;
   assign rsp_any_discovered = seen_any_ff;
   assign rsp_segment_total  = TOTAL_W'(seg_cnt_ff);
   assign rsp_point_total    = TOTAL_W'(pt_cnt_ff);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (seg_cnt_ff <= CNT_W'(MAX_SEGMENTS)) && (pt_cnt_ff <= CNT_W'(MAX_POINTS)))
      else $error("entry count beyond table depth");
   a_any_matches: assert property (@(posedge clock) disable iff (reset)
      seen_any_ff == ((|seg_seen_ff) || (|pt_seen_ff)))
      else $error("any-discovered flag out of step with the entry bits");

endmodule

@@ design/spr_mac.sv @@
// spr_mac: shared signed multiply-accumulate unit, one partial product per cycle
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_mac import spr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  mac_cmd_type             cmd,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff;
   shift_type                sh_ff;
   logic signed [ACC_W-1:0]  acc_ff, addend;

   always_comb begin
      prod_in = $signed(cmd.op_a) * $signed(cmd.op_b);
      if (cmd.neg) begin
         prod_in = -prod_in;
      end
   end

   always_comb begin
      case (sh_ff)
         SH_NONE: addend = ACC_W'(prod_ff);
         SH_ONE:  addend = ACC_W'(prod_ff) <<< LIMB_W;
         SH_TWO:  addend = ACC_W'(prod_ff) <<< (2 * LIMB_W);
         default: addend = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sh_ff   <= cmd.shift;
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.load) begin
         acc_ff <= cmd.init;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + addend;
      end
   end

   assign acc = acc_ff;

   a_load_no_issue: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.issue))
      else $error("load and issue together");
   a_load_no_pending: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && prod_vld_ff))
      else $error("load would drop a pending product");
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      (!cmd.load && !prod_vld_ff) |=> $stable(acc_ff))
      else $error("accumulator moved without a product");

endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for segment_proximity_reveal_table
// depends on spr_pkg and the block; holds its own exact-arithmetic table predictor
// directed corner cases, then random traffic with fill bursts, idle gaps and a drain pause
`timescale 1ns / 1ps

import spr_pkg::*;

// one request transaction as driven on the req_ ports
typedef struct {
   logic [FUNC_W-1:0]            func;
   logic [INDEX_W-1:0]           index;
   logic signed [COORD_BITS-1:0] first_x;
   logic signed [COORD_BITS-1:0] first_y;
   logic signed [COORD_BITS-1:0] second_x;
   logic signed [COORD_BITS-1:0] second_y;
   logic signed [COORD_BITS-1:0] radius;
} table_request_type;

// one response transaction
typedef struct {
   logic [STATUS_W-1:0] status;
   logic                flag;
   logic                any_discovered;
   logic [TOTAL_W-1:0]  segment_total;
   logic [TOTAL_W-1:0]  point_total;
} table_response_type;

class reveal_scoreboard;
   longint             seg_ax[MAX_SEGMENTS], seg_ay[MAX_SEGMENTS];
   longint             seg_bx[MAX_SEGMENTS], seg_by[MAX_SEGMENTS];
   bit                 seg_found[MAX_SEGMENTS];
   longint             pt_x[MAX_POINTS], pt_y[MAX_POINTS];
   bit                 pt_found[MAX_POINTS];
   int                 seg_cnt, pt_cnt;
   bit                 found_any;
   table_response_type pending[$];
   int                 failures;

   function new();
      seg_cnt   = 0;
      pt_cnt    = 0;
      found_any = 0;
      failures  = 0;
      foreach (seg_found[i]) seg_found[i] = 0;
      foreach (pt_found[i]) pt_found[i] = 0;
   endfunction

   // exact closest-distance test of segment i against a circle
   function bit segment_within(int i, longint cx, longint cy, logic signed [127:0] r2);
      logic signed [127:0] ex, ey, wx, wy, vx, vy, len2, w2, dot, crs;
      ex   = seg_bx[i] - seg_ax[i];
      ey   = seg_by[i] - seg_ay[i];
      wx   = cx - seg_ax[i];
      wy   = cy - seg_ay[i];
      len2 = ex * ex + ey * ey;
      w2   = wx * wx + wy * wy;
      if (len2 == 0) return w2 <= r2;
      dot = ex * wx + ey * wy;
      if (dot <= 0) return w2 <= r2;
      if (dot >= len2) begin
         vx = cx - seg_bx[i];
         vy = cy - seg_by[i];
         return (vx * vx + vy * vy) <= r2;
      end
      crs = ex * wy - ey * wx;
      return (crs * crs) <= (r2 * len2);
   endfunction

   // work out the response of an accepted request and queue it
   function void note_request(table_request_type rq);
      table_response_type  rs;
      logic signed [127:0] r2, dx, dy;
      longint              cx, cy, rad;
      cx  = rq.first_x;
      cy  = rq.first_y;
      rad = rq.radius;
      rs.status = STAT_DONE;
      rs.flag   = 0;
      case (rq.func)
         F_CLEAR: begin
            seg_cnt   = 0;
            pt_cnt    = 0;
            found_any = 0;
            foreach (seg_found[i]) seg_found[i] = 0;
            foreach (pt_found[i]) pt_found[i] = 0;
         end
         F_ADD_SEG: begin
            if (seg_cnt >= MAX_SEGMENTS) rs.status = STAT_FULL;
            else begin
               seg_ax[seg_cnt]    = rq.first_x;
               seg_ay[seg_cnt]    = rq.first_y;
               seg_bx[seg_cnt]    = rq.second_x;
               seg_by[seg_cnt]    = rq.second_y;
               seg_found[seg_cnt] = 0;
               seg_cnt++;
            end
         end
         F_ADD_PT: begin
            if (pt_cnt >= MAX_POINTS) rs.status = STAT_FULL;
            else begin
               pt_x[pt_cnt]     = rq.first_x;
               pt_y[pt_cnt]     = rq.first_y;
               pt_found[pt_cnt] = 0;
               pt_cnt++;
            end
         end
         F_REVEAL: begin
            if (rad < 0) rad = 0;
            r2 = rad;
            r2 = r2 * r2;
            for (int i = 0; i < seg_cnt; i++) begin
               if (!seg_found[i] && segment_within(i, cx, cy, r2)) seg_found[i] = 1;
               if (seg_found[i]) found_any = 1;
            end
            for (int i = 0; i < pt_cnt; i++) begin
               dx = pt_x[i] - cx;
               dy = pt_y[i] - cy;
               if (!pt_found[i] && (dx * dx + dy * dy) <= r2) pt_found[i] = 1;
               if (pt_found[i]) found_any = 1;
            end
         end
         F_READ_SEG: begin
            if (rq.index >= seg_cnt) rs.status = STAT_RANGE;
            else rs.flag = seg_found[rq.index];
         end
         F_READ_PT: begin
            if (rq.index >= pt_cnt) rs.status = STAT_RANGE;
            else rs.flag = pt_found[rq.index];
         end
         default: ;
      endcase
      rs.any_discovered = found_any;
      rs.segment_total  = TOTAL_W'(seg_cnt);
      rs.point_total    = TOTAL_W'(pt_cnt);
      pending.insert(pending.size(), rs);
   endfunction

   function void check_response(table_response_type got);
      table_response_type want;
      if (pending.size() == 0) begin
         $error("response with no request outstanding");
         failures++;
         return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
         $error("status expected %0d actual %0d", want.status, got.status);
         failures++;
      end
      if (got.flag !== want.flag) begin
         $error("flag expected %0d actual %0d", want.flag, got.flag);
         failures++;
      end
      if (got.any_discovered !== want.any_discovered) begin
         $error("any_discovered expected %0d actual %0d",
                want.any_discovered, got.any_discovered);
         failures++;
      end
      if (got.segment_total !== want.segment_total) begin
         $error("segment_total expected %0d actual %0d",
                want.segment_total, got.segment_total);
         failures++;
      end
      if (got.point_total !== want.point_total) begin
         $error("point_total expected %0d actual %0d", want.point_total, got.point_total);
         failures++;
      end
   endfunction
endclass

module testbench;

   // func codes the block leaves unused
   localparam logic [FUNC_W-1:0] F_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] F_SPARE_HI = 3'd7;
   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 420;
   localparam int FILL_ITEMS = 70;       // a little past a full table

   localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   logic                         clock = 0;
   logic                         reset = 1;
   logic                         start = 0;
   logic                         busy;
   logic [FUNC_W-1:0]            req_func = F_CLEAR;
   logic [INDEX_W-1:0]           req_index = '0;
   logic signed [COORD_BITS-1:0] req_first_x = '0;
   logic signed [COORD_BITS-1:0] req_first_y = '0;
   logic signed [COORD_BITS-1:0] req_second_x = '0;
   logic signed [COORD_BITS-1:0] req_second_y = '0;
   logic signed [COORD_BITS-1:0] req_radius = '0;
   logic                         rsp_strobe;
   logic [STATUS_W-1:0]          rsp_status;
   logic                         rsp_flag;
   logic                         rsp_any_discovered;
   logic [TOTAL_W-1:0]           rsp_segment_total;
   logic [TOTAL_W-1:0]           rsp_point_total;

   reveal_scoreboard table_model = new();
   int  idle_cycles = 0;
   bit  no_gaps = 0;     // stretches of back-to-back transactions

   always #10 clock = ~clock;

   segment_proximity_reveal_table i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_index          (req_index),
      .req_first_x        (req_first_x),
      .req_first_y        (req_first_y),
      .req_second_x       (req_second_x),
      .req_second_y       (req_second_y),
      .req_radius         (req_radius),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_flag           (rsp_flag),
      .rsp_any_discovered (rsp_any_discovered),
      .rsp_segment_total  (rsp_segment_total),
      .rsp_point_total    (rsp_point_total)
   );

   // response monitor: one strobe per transaction, checked in order
   always @(posedge clock) begin
      table_response_type got;
      if (!reset && rsp_strobe) begin
         got.status         = rsp_status;
         got.flag           = rsp_flag;
         got.any_discovered = rsp_any_discovered;
         got.segment_total  = rsp_segment_total;
         got.point_total    = rsp_point_total;
         table_model.check_response(got);
      end
   end

   // watchdog: cycles with neither a request nor a response taken
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("** segment_proximity_reveal_table: FAILED **");
         $finish;
      end
   end

   // drive one transaction; start stays high when the next one follows without a gap
   task automatic send(table_request_type rq);
      int  gap;
      bit  taken;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start = 0;
         repeat (gap) @(negedge clock);
      end
      start        = 1;
      req_func     = rq.func;
      req_index    = rq.index;
      req_first_x  = rq.first_x;
      req_first_y  = rq.first_y;
      req_second_x = rq.second_x;
      req_second_y = rq.second_y;
      req_radius   = rq.radius;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         if (!busy) begin
            taken = 1;
            table_model.note_request(rq);
         end
         @(negedge clock);
      end
   endtask

   task automatic drain();
      start = 0;
      while (table_model.pending.size() != 0) @(negedge clock);
   endtask

   // coordinates: mostly a tight cluster so reveals actually hit, plus full range and rails
   function automatic logic signed [COORD_BITS-1:0] pick_coord();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return COORD_BITS'($urandom_range(0, 4095)) - COORD_BITS'(2048);
      if (sel < 8) return COORD_BITS'($urandom);
      case ($urandom_range(0, 3))
         0: return C_MIN;
         1: return C_MAX;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_radius();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 3) return C_MIN | COORD_BITS'($urandom);          // negative
      if (sel < 13) return COORD_BITS'($urandom_range(0, 2047));
      if (sel < 17) return COORD_BITS'($urandom);
      return (sel == 17) ? C_MAX : '0;
   endfunction

   function automatic table_request_type make_request(logic [FUNC_W-1:0] f);
      table_request_type rq;
      int                cnt;
      rq.func     = f;
      rq.first_x  = pick_coord();
      rq.first_y  = pick_coord();
      // short segments around the start point are the common case
      if ($urandom_range(0, 3) != 0) begin
         rq.second_x = rq.first_x + COORD_BITS'($urandom_range(0, 1023)) - COORD_BITS'(512);
         rq.second_y = rq.first_y + COORD_BITS'($urandom_range(0, 1023)) - COORD_BITS'(512);
      end else begin
         rq.second_x = pick_coord();
         rq.second_y = pick_coord();
      end
      rq.radius = pick_radius();
      cnt = (f == F_READ_SEG) ? table_model.seg_cnt : table_model.pt_cnt;
      if (cnt > 0 && $urandom_range(0, 9) < 7) rq.index = INDEX_W'($urandom_range(0, cnt - 1));
      else rq.index = INDEX_W'($urandom);
      return rq;
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func();
      int sel;
      sel = $urandom_range(0, 199);
      if (sel == 0) return F_CLEAR;
      if (sel < 60) return F_ADD_SEG;
      if (sel < 100) return F_ADD_PT;
      if (sel < 135) return F_REVEAL;
      if (sel < 165) return F_READ_SEG;
      if (sel < 195) return F_READ_PT;
      return (sel < 197) ? F_SPARE_LO : F_SPARE_HI;
   endfunction

   // directed request with explicit fields
   task automatic send_fixed(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx,
                             logic signed [COORD_BITS-1:0] ax, logic signed [COORD_BITS-1:0] ay,
                             logic signed [COORD_BITS-1:0] bx, logic signed [COORD_BITS-1:0] by,
                             logic signed [COORD_BITS-1:0] rad);
      table_request_type rq;
      rq.func     = f;
      rq.index    = idx;
      rq.first_x  = ax;
      rq.first_y  = ay;
      rq.second_x = bx;
      rq.second_y = by;
      rq.radius   = rad;
      send(rq);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty reads, zero-length segment, rails, negative radius, spare codes
      send_fixed(F_READ_SEG, '1, '0, '0, '0, '0, '0);
      send_fixed(F_READ_PT, '0, '0, '0, '0, '0, '0);
      send_fixed(F_ADD_SEG, '0, 24'sd256, 24'sd256, 24'sd256, 24'sd256, '0);
      send_fixed(F_ADD_SEG, '0, C_MIN, C_MIN, C_MAX, C_MAX, '0);
      send_fixed(F_ADD_SEG, '0, -24'sd1024, '0, 24'sd1024, '0, '0);
      send_fixed(F_ADD_PT, '0, C_MAX, C_MIN, '0, '0, '0);
      send_fixed(F_ADD_PT, '0, 24'sd10, 24'sd10, '0, '0, '0);
      send_fixed(F_REVEAL, '0, 24'sd10, 24'sd10, '0, '0, C_MIN);     // clamped to zero
      send_fixed(F_READ_PT, 6'd1, '0, '0, '0, '0, '0);
      send_fixed(F_READ_PT, 6'd2, '0, '0, '0, '0, '0);
      send_fixed(F_REVEAL, '0, '0, 24'sd300, '0, '0, 24'sd300);     // perpendicular hit
      send_fixed(F_REVEAL, '0, 24'sd256, 24'sd300, '0, '0, 24'sd44); // zero-length edge
      send_fixed(F_READ_SEG, 6'd0, '0, '0, '0, '0, '0);
      send_fixed(F_READ_SEG, 6'd2, '0, '0, '0, '0, '0);
      send_fixed(F_REVEAL, '0, C_MIN, C_MAX, '0, '0, C_MAX);        // far corner
      send_fixed(F_READ_SEG, 6'd1, '0, '0, '0, '0, '0);
      send_fixed(F_READ_PT, 6'd0, '0, '0, '0, '0, '0);
      send_fixed(F_SPARE_LO, '1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
      send_fixed(F_SPARE_HI, '0, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
      send_fixed(F_CLEAR, '0, '0, '0, '0, '0, '0);
      send_fixed(F_READ_SEG, 6'd0, '0, '0, '0, '0, '0);

      // fill both tables past capacity, then reveal and read over the full tables
      for (int n = 0; n < FILL_ITEMS; n++) send(make_request(F_ADD_SEG));
      for (int n = 0; n < FILL_ITEMS; n++) send(make_request(F_ADD_PT));
      for (int n = 0; n < 20; n++)
         send(make_request($urandom_range(0, 1) ? F_REVEAL
                           : ($urandom_range(0, 1) ? F_READ_SEG : F_READ_PT)));

      // random traffic with gap-free stretches and one full drain pause
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) drain();
         send(make_request(pick_func()));
      end

      drain();
      repeat (50) @(negedge clock);
      if (table_model.failures == 0 && table_model.pending.size() == 0)
         $display("** segment_proximity_reveal_table: PASSED **");
      else
         $display("** segment_proximity_reveal_table: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
design/spr_pkg.sv
design/spr_mac.sv
design/segment_proximity_reveal_table.sv
bench/testbench.sv
